@@ hdl/solenoid_pulse_slot_timer_core_assert.svh @@
`ifndef SOLENOID_PULSE_SLOT_TIMER_CORE_ASSERT_SVH
`define SOLENOID_PULSE_SLOT_TIMER_CORE_ASSERT_SVH

// Same-cycle check on clk, off while arst_n is low.
`define SPST_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Next-cycle check: pre at one edge implies post at the following one.
`define SPST_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hdl/spst_pkg.sv @@
package spst_pkg;

	localparam int NUM_LOCKS = 40;
	localparam int NUM_SLOTS = 5;
	localparam int TIME_BITS = 8;

	localparam int ACTION_W  = 2;
	localparam int LOCK_ID_W = 6;
	localparam int PATTERN_W = 40;
	localparam int STATUS_W  = 2;
	localparam int EXP_W     = 3;
	localparam int HOLD_W    = 8;
	// wide enough for the largest slot count
	localparam int CNT_W     = 5;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd20;
	localparam logic [EXP_W-1:0]  EXP_MAX    = 3'd7;

	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_OPEN  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BUSY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

	typedef logic [NUM_LOCKS-1:0] lock_vec_t;

	// command from the top level to the slot table
	typedef struct packed {
		logic                 fire;
		logic                 tick;
		logic                 open_req;
		logic [LOCK_ID_W-1:0] id;
		logic [HOLD_W-1:0]    hold;
	} spst_cmd_t;

	// what the slot table reports for the current command
	typedef struct packed {
		lock_vec_t        clear_mask;
		logic [EXP_W-1:0] expired;
		logic             full;
	} spst_slot_res_t;

	// lock n drives bit n-1; id 0 decodes to no bit
	function automatic lock_vec_t lock_onehot(input logic [LOCK_ID_W-1:0] id);
		lock_vec_t v;
		for (int n = 0; n < NUM_LOCKS; n++) begin
			v[n] = ({1'b0, id} == (LOCK_ID_W+1)'(n + 1));
		end
		return v;
	endfunction

endpackage

@@ hdl/spst_if.sv @@
interface spst_req_if import spst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ACTION_W-1:0]  action;
	logic [LOCK_ID_W-1:0] lock_id;

	modport source (output valid, output action, output lock_id, input ready);
	modport sink   (input valid, input action, input lock_id, output ready);
endinterface

interface spst_rsp_if import spst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PATTERN_W-1:0] lock_pattern;
	logic [STATUS_W-1:0]  status;
	logic [EXP_W-1:0]     expired_count;

	modport source (output valid, output lock_pattern, output status, output expired_count,
		input ready);
	modport sink   (input valid, input lock_pattern, input status, input expired_count,
		output ready);
endinterface

@@ hdl/spst_slot_table.sv @@
module spst_slot_table import spst_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  spst_cmd_t      cmd,
	output spst_slot_res_t res
);

	localparam int SUM_W = TIME_BITS + HOLD_W;

	logic [LOCK_ID_W-1:0] slot_lock_q [NUM_SLOTS];
	logic [TIME_BITS-1:0] slot_dl_q   [NUM_SLOTS];
	logic [TIME_BITS-1:0] tick_now_q;

	logic [TIME_BITS-1:0] tick_next;
	logic [TIME_BITS-1:0] deadline;
	logic [SUM_W-1:0]     dl_sum;
	logic [NUM_SLOTS-1:0] expire;
	logic [NUM_SLOTS-1:0] is_free;
	logic [NUM_SLOTS-1:0] pick;
	logic [CNT_W-1:0]     cnt;
	lock_vec_t            clr;

	assign tick_next = tick_now_q + TIME_BITS'(1);
	assign dl_sum    = SUM_W'(tick_now_q) + SUM_W'(cmd.hold);
	assign deadline  = dl_sum[TIME_BITS-1:0];

	always_comb begin
		clr = '0;
		cnt = '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			is_free[s] = (slot_lock_q[s] == '0);
			expire[s]  = !is_free[s] && (slot_dl_q[s] == tick_next);
			if (expire[s]) begin
				clr = clr | lock_onehot(slot_lock_q[s]);
			end
			cnt = cnt + CNT_W'(expire[s]);
		end
	end

	// lowest free slot, one-hot
	always_comb begin
		pick = '0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (is_free[s]) begin
				pick = '0;
				pick[s] = 1'b1;
			end
		end
	end

	assign res.clear_mask = clr;
	assign res.expired    = (cnt > CNT_W'(EXP_MAX)) ? EXP_MAX : cnt[EXP_W-1:0];
	assign res.full       = (is_free == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now_q <= '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_lock_q[s] <= '0;
				slot_dl_q[s]   <= '0;
			end
		end else if (cmd.fire) begin
			if (cmd.tick) begin
				tick_now_q <= tick_next;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (expire[s]) begin
						slot_lock_q[s] <= '0;
					end
				end
			end else if (cmd.open_req) begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (pick[s]) begin
						slot_lock_q[s] <= cmd.id;
						slot_dl_q[s]   <= deadline;
					end
				end
			end
		end
	end

endmodule

@@ hdl/solenoid_pulse_slot_timer_core.sv @@
// Path: an accepted request item passes the input register, then slot
//   compare / priority pick into the result register, to its result item.
// Throughput: 1 item/cycle unless rsp stalls; slot table updates once per item.
// Reset (arst_n low, asynchronous): locks off, all slots free, time 0,
//   hold_ticks back to 20, both pipeline stages empty. No clearing pass.
module solenoid_pulse_slot_timer_core import spst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	spst_req_if.sink          req,
	spst_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [HOLD_W-1:0] cfg_wdata
);

	`include "solenoid_pulse_slot_timer_core_assert.svh"

	// stage 1: captured request item
	logic                 valid_s1;
	logic [ACTION_W-1:0]  action_s1;
	logic [LOCK_ID_W-1:0] lock_id_s1;

	// stage 2: result register, drives rsp directly
	logic                 valid_s2;
	logic [PATTERN_W-1:0] pattern_s2;
	logic [STATUS_W-1:0]  status_s2;
	logic [EXP_W-1:0]     expired_s2;

	logic [HOLD_W-1:0]    hold_ticks_q;
	lock_vec_t            lock_bits_q;

	logic                 adv;
	logic                 id_ok;
	spst_cmd_t            cmd;
	spst_slot_res_t       slot_res;

	lock_vec_t            bits_next;
	logic [STATUS_W-1:0]  status_next;
	logic [EXP_W-1:0]     expired_next;

	// stage 1 moves whenever the result register is empty or being drained;
	// a waiting result that is not drained holds stage 1 and the next request item.
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// lock ids 1..NUM_LOCKS are real locks
	assign id_ok = (lock_id_s1 != '0) &&
		({1'b0, lock_id_s1} <= (LOCK_ID_W+1)'(NUM_LOCKS));

	assign cmd.fire     = adv;
	assign cmd.tick     = (action_s1 == ACT_TICK);
	assign cmd.open_req = (action_s1 == ACT_OPEN) && id_ok;
	assign cmd.id       = lock_id_s1;
	assign cmd.hold     = hold_ticks_q;

	spst_slot_table u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (slot_res)
	);

	always_comb begin
		bits_next    = lock_bits_q;
		status_next  = STAT_DONE;
		expired_next = '0;
		case (action_s1)
			ACT_TICK: begin
				bits_next    = lock_bits_q & ~slot_res.clear_mask;
				expired_next = slot_res.expired;
			end
			ACT_OPEN: begin
				if (!id_ok) begin
					status_next = STAT_INVALID;
				end else if (slot_res.full) begin
					// caller retries later
					status_next = STAT_BUSY;
				end else begin
					bits_next = lock_bits_q | lock_onehot(lock_id_s1);
				end
			end
			ACT_CLOSE: begin
				// slots stay occupied and still expire on schedule
				bits_next = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg_we) begin
			hold_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			lock_bits_q <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				valid_s2    <= 1'b1;
				lock_bits_q <= bits_next;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1  <= req.action;
			lock_id_s1 <= req.lock_id;
		end
		if (adv) begin
			pattern_s2 <= PATTERN_W'(bits_next);
			status_s2  <= status_next;
			expired_s2 <= expired_next;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.lock_pattern  = pattern_s2;
	assign rsp.status        = status_s2;
	assign rsp.expired_count = expired_s2;

	`SPST_ASSERT_NEXT(a_busy_when_full,
		adv && (action_s1 == ACT_OPEN) && id_ok && slot_res.full,
		valid_s2 && (status_s2 == STAT_BUSY), "open with no free slot not reported busy")
	`SPST_ASSERT_NEXT(a_close_clears, adv && (action_s1 == ACT_CLOSE),
		(lock_bits_q == '0) && (pattern_s2 == '0), "close-all left a lock energized")
	`SPST_ASSERT_NEXT(a_expire_only_tick, adv && (action_s1 != ACT_TICK),
		expired_s2 == '0, "expiry counted on a non-tick item")
	`SPST_ASSERT_NOW(a_result_mirrors_state, !valid_s2 || (pattern_s2 == PATTERN_W'(lock_bits_q)),
		"pending result differs from lock state")

endmodule
